// ----- rtl/cma_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_pkg: shared types and constants for the cascaded moving average
// Sizes of the history memory, the running sums and the divider, plus
// register indexes and the history write bundle.
// ----------------------------------------------------------------------------
package cma_pkg;

    localparam int MAX_STAGES   = 8;
    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_WIDTH = 16;

    localparam int CNT_W   = $clog2(MAX_STAGES + 1);       // stage count register
    localparam int WIN_W   = $clog2(MAX_WINDOW + 1);       // window length register
    localparam int STAGE_W = $clog2(MAX_STAGES);           // stage index
    localparam int SLOT_W  = $clog2(MAX_WINDOW);           // ring slot index
    localparam int ADDR_W  = STAGE_W + SLOT_W;             // history address
    localparam int DEPTH   = MAX_STAGES * MAX_WINDOW;
    localparam int SUM_W   = SAMPLE_WIDTH + WIN_W;         // running sum, signed
    localparam int DCNT_W  = $clog2(SUM_W);                // divider step counter
    localparam int CFG_W   = (WIN_W > CNT_W) ? WIN_W : CNT_W;
    localparam int IDX_W   = 1;

    localparam logic [IDX_W-1:0] REG_STAGE_COUNT = 1'b0;
    localparam logic [IDX_W-1:0] REG_WINDOW_LEN  = 1'b1;

    typedef struct packed {
        logic                    we;
        logic [ADDR_W-1:0]       addr;
        logic [SAMPLE_WIDTH-1:0] data;
    } t_hist_wr;

endpackage

// ----- rtl/cascaded_moving_average.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_moving_average: cascade of boxcar filters on signed samples
// Up to eight moving average stages in series sharing one history memory
// and one iterative divider under a small sequencer.
// ----------------------------------------------------------------------------
// One item at a time. A normal item runs each stage in turn: history read,
// sum update and write-back, then divide by the window length in the
// shared bit-serial divider. The first item after reset or after any
// register write primes the filter: it fills every slot of every ring in
// use, one history write per cycle, and its result is the sample itself.
// A finished result sits in the output register; the next item is not
// taken until that result has moved into it. Registers are written with
// i_cfg_we, index 0 = stage count (low 4 data bits; 0 reads as 1, above 8
// clamps to 8), index 1 = window length (0 reads as 1, above 64 clamps to
// 64); either write forces a new priming pass. Write only while idle.
// ----------------------------------------------------------------------------
module cascaded_moving_average (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // sample channel
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic signed [cma_pkg::SAMPLE_WIDTH-1:0]  i_sample,
    // result channel
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic signed [cma_pkg::SAMPLE_WIDTH-1:0]  o_filtered,
    // register writes
    input  logic                                     i_cfg_we,
    input  logic [cma_pkg::IDX_W-1:0]                i_cfg_index,
    input  logic [cma_pkg::CFG_W-1:0]                i_cfg_data
);

    localparam int SW  = cma_pkg::SUM_W;
    localparam int XW  = cma_pkg::SAMPLE_WIDTH;
    localparam int CW  = cma_pkg::CNT_W;
    localparam int WW  = cma_pkg::WIN_W;
    localparam int STW = cma_pkg::STAGE_W;
    localparam int SLW = cma_pkg::SLOT_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_FILL = 6'b000010,
        S_READ = 6'b000100,
        S_CALC = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;         // stages in use
    logic [WW-1:0]         r_win, n_win;         // window length
    logic                  r_primed, n_primed;
    logic [SLW-1:0]        r_pos, n_pos;         // shared ring position
    logic [STW-1:0]        r_stage, n_stage;
    logic [SLW-1:0]        r_slot, n_slot;       // priming sweep slot
    logic signed [XW-1:0]  r_x, n_x;             // value moving down the cascade
    logic signed [SW-1:0]  r_psum, n_psum;       // sample * window for priming
    logic signed [SW-1:0]  r_sums [cma_pkg::MAX_STAGES];
    logic                  r_out_valid, n_out_valid;
    logic signed [XW-1:0]  r_out, n_out;

    logic                  sum_we;
    logic signed [SW-1:0]  sum_wdata;
    cma_pkg::t_hist_wr     hist_wr;
    logic [cma_pkg::ADDR_W-1:0] hist_raddr;
    logic [XW-1:0]         hist_rdata;
    logic                  div_start;
    logic                  div_done;
    logic signed [XW-1:0]  div_quo;
    logic signed [SW-1:0]  new_sum;
    logic                  last_stage;
    logic                  last_slot;
    logic [WW-1:0]         pos_inc;
    logic [CW-1:0]         cfg_cnt;
    logic [WW-1:0]         cfg_win;

    // ---- configuration clamping ----
    always_comb begin
        cfg_cnt = i_cfg_data[CW-1:0];
        if (cfg_cnt == '0) begin
            cfg_cnt = CW'(1);
        end else if (cfg_cnt > CW'(cma_pkg::MAX_STAGES)) begin
            cfg_cnt = CW'(cma_pkg::MAX_STAGES);
        end
        cfg_win = i_cfg_data[WW-1:0];
        if (cfg_win == '0) begin
            cfg_win = WW'(1);
        end else if (cfg_win > WW'(cma_pkg::MAX_WINDOW)) begin
            cfg_win = WW'(cma_pkg::MAX_WINDOW);
        end
    end

    assign last_stage = (CW'(r_stage) == r_cnt - 1'b1);
    assign last_slot  = (WW'(r_slot) == r_win - 1'b1);
    assign pos_inc    = WW'(r_pos) + 1'b1;

    // stage sum update: drop the oldest value, add the new one
    assign new_sum = r_sums[r_stage]
                   - {{(SW-XW){hist_rdata[XW-1]}}, hist_rdata}
                   + {{(SW-XW){r_x[XW-1]}}, r_x};

    assign hist_raddr = {r_stage, r_pos};
    assign o_in_ready = (r_state == S_IDLE);

    // ---- sequencer ----
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_win       = r_win;
        n_primed    = r_primed;
        n_pos       = r_pos;
        n_stage     = r_stage;
        n_slot      = r_slot;
        n_x         = r_x;
        n_psum      = r_psum;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        sum_we      = 1'b0;
        sum_wdata   = new_sum;
        div_start   = 1'b0;
        hist_wr.we   = 1'b0;
        hist_wr.addr = {r_stage, r_pos};
        hist_wr.data = r_x;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_x     = i_sample;
                    n_stage = '0;
                    n_slot  = '0;
                    n_psum  = $signed({{(SW-XW){i_sample[XW-1]}}, i_sample})
                            * $signed({{(SW-WW){1'b0}}, r_win});
                    n_state = r_primed ? S_READ : S_FILL;
                end
            end
            S_FILL: begin
                hist_wr.we   = 1'b1;
                hist_wr.addr = {r_stage, r_slot};
                if (last_slot) begin
                    sum_we    = 1'b1;
                    sum_wdata = r_psum;
                    n_slot    = '0;
                    if (last_stage) begin
                        n_primed = 1'b1;
                        n_pos    = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_stage = r_stage + 1'b1;
                    end
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_READ: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                sum_we     = 1'b1;
                hist_wr.we = 1'b1;
                div_start  = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_x = div_quo;
                    if (last_stage) begin
                        n_pos   = (pos_inc == r_win) ? '0 : SLW'(pos_inc);
                        n_state = S_DONE;
                    end else begin
                        n_stage = r_stage + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_x;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register writes are to land only while idle (the block itself does not enforce it); any known index re-primes
        if (i_cfg_we) begin
            case (i_cfg_index)
                cma_pkg::REG_STAGE_COUNT: begin
                    n_cnt    = cfg_cnt;
                    n_primed = 1'b0;
                    n_pos    = '0;
                end
                cma_pkg::REG_WINDOW_LEN: begin
                    n_win    = cfg_win;
                    n_primed = 1'b0;
                    n_pos    = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= CW'(1);
            r_win       <= WW'(1);
            r_primed    <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < cma_pkg::MAX_STAGES; i++) begin
                r_sums[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_win       <= n_win;
            r_primed    <= n_primed;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            if (sum_we) begin
                r_sums[r_stage] <= sum_wdata;
            end
        end
        r_stage <= n_stage;
        r_slot  <= n_slot;
        r_x     <= n_x;
        r_psum  <= n_psum;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_out;

    cma_hist u_hist (
        .i_clk   (i_clk),
        .i_wr    (hist_wr),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    cma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (new_sum),
        .i_divisor  (r_win),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

`ifndef SYNTHESIS
    // priming sweep never runs on a primed filter
    a_fill_unprimed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> !r_primed)
        else $error("priming sweep with filter already primed");

    // ring position stays inside the window while stages run
    a_pos_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (WW'(r_pos) < r_win))
        else $error("ring position outside window");

    // a finished priming pass leaves the filter primed
    a_primed_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && $past(r_state) == S_FILL) |-> r_primed)
        else $error("priming pass ended without primed flag");

    // divider results only arrive while the sequencer waits on them
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");
`endif

endmodule

// ----- rtl/cma_hist.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_hist: history ring storage
// One write port and one read port, read data registered. All stage rings
// share the array; stage s, slot p sits at address {s, p}.
// ----------------------------------------------------------------------------
module cma_hist (
    input  logic                              i_clk,
    input  cma_pkg::t_hist_wr                 i_wr,
    input  logic [cma_pkg::ADDR_W-1:0]        i_raddr,
    output logic [cma_pkg::SAMPLE_WIDTH-1:0]  o_rdata
);

    logic [cma_pkg::SAMPLE_WIDTH-1:0] r_mem [cma_pkg::DEPTH];
    logic [cma_pkg::SAMPLE_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cma_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_div: iterative signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// Done pulses in the cycle after the last step; quotient holds until restart.
// ----------------------------------------------------------------------------
module cma_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [cma_pkg::SUM_W-1:0]  i_dividend,
    input  logic [cma_pkg::WIN_W-1:0]         i_divisor,
    output logic                              o_done,
    output logic signed [cma_pkg::SAMPLE_WIDTH-1:0] o_quotient
);

    localparam int SW = cma_pkg::SUM_W;
    localparam int WW = cma_pkg::WIN_W;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [cma_pkg::DCNT_W-1:0] r_cnt, n_cnt;
    logic [WW-1:0]     r_rem, n_rem;
    logic [SW-1:0]     r_quo, n_quo;
    logic              r_neg, n_neg;
    logic [WW:0]       trial;
    logic [SW-1:0]     mag;
    logic [SW-1:0]     quo_signed;

    assign mag   = i_dividend[SW-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign trial = {r_rem, r_quo[SW-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = cma_pkg::DCNT_W'(SW - 1);
            n_rem  = '0;
            n_quo  = mag;
            n_neg  = i_dividend[SW-1];
        end else if (r_busy) begin
            if (trial >= {1'b0, i_divisor}) begin
                n_rem = WW'(trial - {1'b0, i_divisor});
                n_quo = {r_quo[SW-2:0], 1'b1};
            end else begin
                n_rem = trial[WW-1:0];
                n_quo = {r_quo[SW-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_neg <= n_neg;
    end

    assign quo_signed = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign o_quotient = quo_signed[cma_pkg::SAMPLE_WIDTH-1:0];
    assign o_done     = r_done;

endmodule
